[rtl/cws_pkg.sv]
// shared types, constants and helpers for the clip window stack unit
// no dependencies; imported by every module of the block

package cws_pkg;

    // register file defaults
    localparam int STACK_DEPTH_DEF = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [14:0] RESET_SCREEN_WIDTH = 15'd128;
    localparam logic [14:0] RESET_SCREEN_HEIGHT = 15'd64;

    // configuration register indexes
    localparam logic [1:0] REG_SHIFT_X = 2'd0;
    localparam logic [1:0] REG_SHIFT_Y = 2'd1;
    localparam logic [1:0] REG_SCREEN_WIDTH = 2'd2;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd3;

    // command codes
    typedef enum logic [2:0] {
        MODE_PIXEL = 3'd0,
        MODE_RECT  = 3'd1,
        MODE_SET   = 3'd2,
        MODE_RESET = 3'd3,
        MODE_PUSH  = 3'd4,
        MODE_POP   = 3'd5
    } mode_t;

    typedef struct packed {
        logic signed [15:0] shift_x;
        logic signed [15:0] shift_y;
        logic [14:0]        screen_width;
        logic [14:0]        screen_height;
    } cfg_t;

    // classified command between front and back
    // pixel: p0/p1 absolute point, flag on screen
    // rect: p0..p3 absolute edges, flag nonzero size
    // set, reset, push: p0..p3 clamped window
    typedef struct packed {
        mode_t              mode;
        logic               flag;
        logic signed [15:0] p0;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
    } item_t;

    typedef struct packed {
        logic               accepted;
        logic signed [15:0] out_left;
        logic signed [15:0] out_top;
        logic signed [15:0] out_right;
        logic signed [15:0] out_bottom;
        logic [2:0]         stack_level;
    } result_t;

    // clamp a corner into 0..maxv, negative test first
    function automatic logic signed [15:0] clamp_coord(
        input logic signed [15:0] v,
        input logic signed [16:0] maxv
    );
        logic signed [15:0] r;
        if (v < 16'sd0)
        begin
            r = 16'sd0;
        end
        else if ($signed({v[15], v}) > maxv)
        begin
            r = maxv[15:0];
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] max16(
        input logic signed [15:0] a,
        input logic signed [15:0] b
    );
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [15:0] min16(
        input logic signed [15:0] a,
        input logic signed [15:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

[rtl/cws_front.sv]
// front end: applies offsets, clamps and orders window corners
// depends on cws_pkg; feeds cws_queue

module cws_front (
    input  logic              s_tvalid,
    input  logic [95:0]       s_tdata,
    input  logic [2:0]        s_tuser,
    input  cws_pkg::cfg_t     cfg,
    output logic              wr_valid,
    output cws_pkg::item_t    wr_item
);
    import cws_pkg::*;

    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic [15:0]        rect_width;
    logic [15:0]        rect_height;
    logic signed [15:0] abs_x;
    logic signed [15:0] abs_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [16:0] max_x;
    logic signed [16:0] max_y;
    logic signed [15:0] ca_x;
    logic signed [15:0] ca_y;
    logic signed [15:0] cb_x;
    logic signed [15:0] cb_y;
    logic               on_screen;
    mode_t              mode;

    // beat unpacking
    assign a_x         = s_tdata[15:0];
    assign a_y         = s_tdata[31:16];
    assign b_x         = s_tdata[47:32];
    assign b_y         = s_tdata[63:48];
    assign rect_width  = s_tdata[79:64];
    assign rect_height = s_tdata[95:80];
    assign mode        = mode_t'(s_tuser);

    // offset with 16-bit wrap, far rectangle edges
    assign abs_x = a_x + cfg.shift_x;
    assign abs_y = a_y + cfg.shift_y;
    assign end_x = abs_x + $signed(rect_width) - 16'sd1;
    assign end_y = abs_y + $signed(rect_height) - 16'sd1;

    // screen bounds, may be -1 for a zero-sized screen
    assign max_x = $signed({2'b00, cfg.screen_width}) - 17'sd1;
    assign max_y = $signed({2'b00, cfg.screen_height}) - 17'sd1;

    assign ca_x = clamp_coord(a_x, max_x);
    assign ca_y = clamp_coord(a_y, max_y);
    assign cb_x = clamp_coord(b_x, max_x);
    assign cb_y = clamp_coord(b_y, max_y);

    assign on_screen = (abs_x >= 16'sd0) && (abs_y >= 16'sd0)
                       && ($signed({abs_x[15], abs_x}) < $signed({2'b00, cfg.screen_width}))
                       && ($signed({abs_y[15], abs_y}) < $signed({2'b00, cfg.screen_height}));

    // classify the command
    always_comb
    begin
        wr_valid     = s_tvalid;
        wr_item.mode = mode;
        wr_item.flag = 1'b0;
        wr_item.p0   = 16'sd0;
        wr_item.p1   = 16'sd0;
        wr_item.p2   = 16'sd0;
        wr_item.p3   = 16'sd0;
        case (mode)
            MODE_PIXEL:
            begin
                wr_item.flag = on_screen;
                wr_item.p0   = abs_x;
                wr_item.p1   = abs_y;
            end
            MODE_RECT:
            begin
                wr_item.flag = (rect_width != 16'd0) && (rect_height != 16'd0);
                wr_item.p0   = abs_x;
                wr_item.p1   = abs_y;
                wr_item.p2   = end_x;
                wr_item.p3   = end_y;
            end
            MODE_SET, MODE_PUSH:
            begin
                wr_item.p0 = min16(ca_x, cb_x);
                wr_item.p1 = min16(ca_y, cb_y);
                wr_item.p2 = max16(ca_x, cb_x);
                wr_item.p3 = max16(ca_y, cb_y);
            end
            MODE_RESET:
            begin
                wr_item.p2 = max_x[15:0];
                wr_item.p3 = max_y[15:0];
            end
            default:
            begin
                wr_item.flag = 1'b0;
            end
        endcase
    end

endmodule

[rtl/cws_queue.sv]
// short command queue between front and back
// depends on cws_pkg for the item type and depth

module cws_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  cws_pkg::item_t    wr_item,
    output logic              rd_valid,
    input  logic              rd_ready,
    output cws_pkg::item_t    rd_item
);
    import cws_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_wr;
    logic           do_rd;

    assign wr_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // pointer wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

[rtl/cws_back.sv]
// back end: clip window state, save stack and result register
// depends on cws_pkg; takes commands from cws_queue

module cws_back #(
    parameter int STACK_DEPTH = cws_pkg::STACK_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_valid,
    output logic              rd_ready,
    input  cws_pkg::item_t    rd_item,
    output logic              res_valid,
    input  logic              res_ready,
    output cws_pkg::result_t  res
);
    import cws_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef struct packed {
        logic signed [15:0] l;
        logic signed [15:0] t;
        logic signed [15:0] r;
        logic signed [15:0] b;
    } win_t;

    win_t           win_reg;
    win_t           win_next;
    win_t           stack_reg [STACK_DEPTH];
    win_t           saved_win;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [CW-1:0]  count_dec;
    logic           out_valid_reg;
    result_t        out_reg;
    result_t        out_next;
    logic           exec;
    logic           push_ok;
    logic           pop_ok;
    logic signed [15:0] il;
    logic signed [15:0] it;
    logic signed [15:0] ir;
    logic signed [15:0] ib;

    assign rd_ready  = !out_valid_reg || res_ready;
    assign exec      = rd_valid && rd_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // stack access
    assign count_dec = count_reg - 1'b1;
    assign saved_win = stack_reg[count_dec[IW-1:0]];
    assign push_ok   = (rd_item.mode == MODE_PUSH) && (count_reg < CW'(STACK_DEPTH));
    assign pop_ok    = (rd_item.mode == MODE_POP) && (count_reg != '0);

    // rectangle intersection with the current window
    assign il = max16(rd_item.p0, win_reg.l);
    assign it = max16(rd_item.p1, win_reg.t);
    assign ir = min16(rd_item.p2, win_reg.r);
    assign ib = min16(rd_item.p3, win_reg.b);

    // command execution
    always_comb
    begin
        win_next   = win_reg;
        count_next = count_reg;
        out_next   = '0;
        case (rd_item.mode)
            MODE_PIXEL:
            begin
                out_next.accepted = rd_item.flag
                                    && (rd_item.p0 >= win_reg.l) && (rd_item.p0 <= win_reg.r)
                                    && (rd_item.p1 >= win_reg.t) && (rd_item.p1 <= win_reg.b);
                out_next.out_left = rd_item.p0;
                out_next.out_top  = rd_item.p1;
            end
            MODE_RECT:
            begin
                if (rd_item.flag && (ir >= il) && (ib >= it))
                begin
                    out_next.accepted   = 1'b1;
                    out_next.out_left   = il;
                    out_next.out_top    = it;
                    out_next.out_right  = ir;
                    out_next.out_bottom = ib;
                end
            end
            MODE_SET, MODE_RESET:
            begin
                win_next          = '{l: rd_item.p0, t: rd_item.p1,
                                      r: rd_item.p2, b: rd_item.p3};
                out_next.accepted = 1'b1;
            end
            MODE_PUSH:
            begin
                if (push_ok)
                begin
                    win_next          = '{l: il, t: it, r: ir, b: ib};
                    count_next        = count_reg + 1'b1;
                    out_next.accepted = 1'b1;
                end
            end
            MODE_POP:
            begin
                if (pop_ok)
                begin
                    win_next          = saved_win;
                    count_next        = count_dec;
                    out_next.accepted = 1'b1;
                end
            end
            default:
            begin
                out_next.accepted = 1'b0;
            end
        endcase
        // window commands report the window left in place
        if ((rd_item.mode != MODE_PIXEL) && (rd_item.mode != MODE_RECT))
        begin
            out_next.out_left   = win_next.l;
            out_next.out_top    = win_next.t;
            out_next.out_right  = win_next.r;
            out_next.out_bottom = win_next.b;
        end
        out_next.stack_level = 3'(count_next);
    end

    // window, depth and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.l     <= 16'sd0;
            win_reg.t     <= 16'sd0;
            win_reg.r     <= $signed({1'b0, RESET_SCREEN_WIDTH}) - 16'sd1;
            win_reg.b     <= $signed({1'b0, RESET_SCREEN_HEIGHT}) - 16'sd1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec)
            begin
                win_reg   <= win_next;
                count_reg <= count_next;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // save stack and result payload
    always_ff @(posedge clk)
    begin
        if (exec && push_ok)
        begin
            stack_reg[count_reg[IW-1:0]] <= win_reg;
        end
        if (exec)
        begin
            out_reg <= out_next;
        end
    end

endmodule

[rtl/clip_window_stack_unit_top.sv]
// top level of the clip window stack unit: config registers and the
// front, queue and back parts; depends on cws_pkg, cws_front, cws_queue, cws_back
//
//  channel   group                  content
//  in        s_tvalid/s_tready      s_tuser: mode; s_tdata: corners and rect size
//  out       m_tvalid/m_tready      m_tuser: accepted; m_tdata: edges, stack level
//  config    cfg_wen/cfg_addr       cfg_wdata: offsets and screen size
//
// one command per cycle sustained while m_tready keeps the result register free;
// m_tvalid rises once the beat has passed the queue slot and the result register
// the back stage's registered window and stack update sets that rate
// the front accepts while the two-entry queue has room, so a stalled output
// fills the queue before s_tready drops
// reset gives an empty stack and the full 128 x 64 screen as window

module clip_window_stack_unit_top #(
    parameter int STACK_DEPTH = cws_pkg::STACK_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                                    // rect_width, rect_height
    input  logic [2:0]   s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // out_left, out_top, out_right, out_bottom,
                                    // stack_level, zero fill
    output logic [0:0]   m_tuser,   // accepted
    input  logic         cfg_wen,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata
);
    import cws_pkg::*;

    cfg_t     cfg_reg;
    item_t    wr_item;
    item_t    rd_item;
    result_t  res;
    logic     wr_valid;
    logic     rd_valid;
    logic     rd_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shift_x       <= 16'sd0;
            cfg_reg.shift_y       <= 16'sd0;
            cfg_reg.screen_width  <= RESET_SCREEN_WIDTH;
            cfg_reg.screen_height <= RESET_SCREEN_HEIGHT;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                REG_SHIFT_X:       cfg_reg.shift_x       <= cfg_wdata;
                REG_SHIFT_Y:       cfg_reg.shift_y       <= cfg_wdata;
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_wdata[14:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_wdata[14:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    cws_front u_front (
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .wr_valid (wr_valid),
        .wr_item  (wr_item)
    );

    cws_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (wr_valid),
        .wr_ready (s_tready),
        .wr_item  (wr_item),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_item  (rd_item)
    );

    cws_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_valid  (rd_valid),
        .rd_ready  (rd_ready),
        .rd_item   (rd_item),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // output beat packing
    assign m_tuser = res.accepted;
    assign m_tdata = {5'd0, res.stack_level, res.out_bottom, res.out_right,
                      res.out_top, res.out_left};

endmodule
